/* hdl/mcblk_pkg.sv */
// ---------------------------------------------------------------------------
// mcblk_pkg: shared types and constants for the blink output controller
// Channel count, command codes, register map, beat payloads and config set.
// ---------------------------------------------------------------------------
`default_nettype none

package mcblk_pkg;

    localparam int CHANNELS = 16;
    localparam int CH_W     = 4;
    localparam int CNT_W    = 5;
    localparam int CODE_W   = 8;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // Operation of a command beat
    localparam logic OP_CMD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Command codes
    localparam logic [CODE_W-1:0] CODE_OFF       = 8'h00;
    localparam logic [CODE_W-1:0] CODE_OFF_ALT   = 8'h55;
    localparam logic [CODE_W-1:0] CODE_STEADY    = 8'h01;
    localparam logic [CODE_W-1:0] CODE_BLINK     = 8'h02;
    localparam logic [CODE_W-1:0] CODE_BLINK_ALT = 8'hAA;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_CTRL_MASK  = 2'd0;
    localparam logic [1:0] REG_BLINK_MASK = 2'd1;
    localparam logic [1:0] REG_BLINK_LIM  = 2'd2;

    // Reset values
    localparam logic [CHANNELS-1:0] CTRL_MASK_RST  = 16'h3FFC;
    localparam logic [CHANNELS-1:0] BLINK_MASK_RST = 16'h00FC;
    localparam logic [CNT_W-1:0]    BLINK_LIM_RST  = 5'd20;

    typedef struct packed {
        logic              op;
        logic [CH_W-1:0]   channel;
        logic [CODE_W-1:0] command_code;
    } cmd_item_t;

    typedef struct packed {
        logic [CHANNELS-1:0] levels;
        logic [CHANNELS-1:0] changed;
    } res_item_t;

    typedef struct packed {
        logic [CHANNELS-1:0] controllable_mask;
        logic [CHANNELS-1:0] blinkable_mask;
        logic [CNT_W-1:0]    blink_limit;
    } cfg_t;

endpackage

`default_nettype wire

/* hdl/multi_channel_blink_output_control_core.sv */
// ---------------------------------------------------------------------------
// multi_channel_blink_output_control_core: sixteen-channel blink controller
// Command beats set channel modes; tick beats advance levels and counters.
// ---------------------------------------------------------------------------
//  channel  | dir | payload      | handshake
//  cmd      | in  | cmd_item_t   | cmd_valid / cmd_stall
//  res      | out | res_item_t   | res_valid / res_stall
//  apb      | in  | 32-bit regs  | psel / penable / pready
//
//  One beat per cycle while the result side does not stall; a command beat, once
//  accepted, passes the input register, then the update and result register.
//  All channels update in parallel in the single update stage.
//  Reset (rst_n low) clears modes, levels, counters and loads register defaults.
//  A stalled result holds the update stage; the input stalls once it is full.
// ---------------------------------------------------------------------------
`default_nettype none

module multi_channel_blink_output_control_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cmd_valid,
    output logic                                cmd_stall,
    input  wire mcblk_pkg::cmd_item_t           cmd,
    output logic                                res_valid,
    input  wire logic                           res_stall,
    output mcblk_pkg::res_item_t                res,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mcblk_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [mcblk_pkg::DATA_W-1:0]   pwdata,
    output logic      [mcblk_pkg::DATA_W-1:0]   prdata,
    output logic                                pready
);

    mcblk_pkg::cfg_t      cfg;
    mcblk_pkg::cmd_item_t stage_item_reg;
    logic                 stage_valid_reg;
    logic                 stage_valid_next;
    mcblk_pkg::res_item_t res_item_reg;
    mcblk_pkg::res_item_t core_result;
    logic                 res_valid_reg;
    logic                 res_valid_next;
    logic                 advance;
    logic                 fire;
    logic                 take;

    mcblk_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mcblk_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (stage_item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // result register free or draining this cycle
    assign advance   = !res_valid_reg || !res_stall;
    assign fire      = stage_valid_reg && advance;
    assign cmd_stall = stage_valid_reg && !advance;
    assign take      = cmd_valid && !cmd_stall;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (fire)
        begin
            stage_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_item_reg <= cmd;
        end
        if (fire)
        begin
            res_item_reg <= core_result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_item_reg;

endmodule

`default_nettype wire

/* hdl/mcblk_cfg.sv */
// ---------------------------------------------------------------------------
// mcblk_cfg: configuration register file
// APB-style write/read of the two channel masks and the blink limit.
// ---------------------------------------------------------------------------
`default_nettype none

module mcblk_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mcblk_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [mcblk_pkg::DATA_W-1:0]   pwdata,
    output logic      [mcblk_pkg::DATA_W-1:0]   prdata,
    output logic                                pready,
    output mcblk_pkg::cfg_t                     cfg
);

    logic [mcblk_pkg::CHANNELS-1:0] ctrl_mask_reg;
    logic [mcblk_pkg::CHANNELS-1:0] blink_mask_reg;
    logic [mcblk_pkg::CNT_W-1:0]    blink_lim_reg;
    logic [1:0]                     reg_index;
    logic                           wr_en;

    assign reg_index = paddr[3:2];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_mask_reg  <= mcblk_pkg::CTRL_MASK_RST;
            blink_mask_reg <= mcblk_pkg::BLINK_MASK_RST;
            blink_lim_reg  <= mcblk_pkg::BLINK_LIM_RST;
        end
        else if (wr_en)
        begin
            case (reg_index)
                mcblk_pkg::REG_CTRL_MASK:
                    ctrl_mask_reg <= pwdata[mcblk_pkg::CHANNELS-1:0];
                mcblk_pkg::REG_BLINK_MASK:
                    blink_mask_reg <= pwdata[mcblk_pkg::CHANNELS-1:0];
                mcblk_pkg::REG_BLINK_LIM:
                    blink_lim_reg <= pwdata[mcblk_pkg::CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_index)
            mcblk_pkg::REG_CTRL_MASK:
                prdata[mcblk_pkg::CHANNELS-1:0] = ctrl_mask_reg;
            mcblk_pkg::REG_BLINK_MASK:
                prdata[mcblk_pkg::CHANNELS-1:0] = blink_mask_reg;
            mcblk_pkg::REG_BLINK_LIM:
                prdata[mcblk_pkg::CNT_W-1:0] = blink_lim_reg;
            default:
                prdata = '0;
        endcase
    end

    assign cfg.controllable_mask = ctrl_mask_reg;
    assign cfg.blinkable_mask    = blink_mask_reg;
    assign cfg.blink_limit       = blink_lim_reg;

endmodule

`default_nettype wire

/* hdl/mcblk_core.sv */
// ---------------------------------------------------------------------------
// mcblk_core: channel state and per-beat update
// Holds on/blink/level bits and blink counters; applies one beat per fire.
// ---------------------------------------------------------------------------
`default_nettype none

module mcblk_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  fire,
    input  wire mcblk_pkg::cmd_item_t  item,
    input  wire mcblk_pkg::cfg_t       cfg,
    output mcblk_pkg::res_item_t       result
);

    logic [mcblk_pkg::CHANNELS-1:0] on_reg;
    logic [mcblk_pkg::CHANNELS-1:0] on_next;
    logic [mcblk_pkg::CHANNELS-1:0] blink_reg;
    logic [mcblk_pkg::CHANNELS-1:0] blink_next;
    logic [mcblk_pkg::CHANNELS-1:0] level_reg;
    logic [mcblk_pkg::CHANNELS-1:0] level_next;
    logic [mcblk_pkg::CNT_W-1:0]    count_reg  [mcblk_pkg::CHANNELS];
    logic [mcblk_pkg::CNT_W-1:0]    count_next [mcblk_pkg::CHANNELS];

    always_comb
    begin
        on_next    = on_reg;
        blink_next = blink_reg;
        level_next = level_reg;
        for (int i = 0; i < mcblk_pkg::CHANNELS; i++)
        begin
            count_next[i] = count_reg[i];
        end

        if (item.op == mcblk_pkg::OP_CMD)
        begin
            for (int i = 0; i < mcblk_pkg::CHANNELS; i++)
            begin
                if (item.channel == mcblk_pkg::CH_W'(i))
                begin
                    case (item.command_code)
                        mcblk_pkg::CODE_OFF, mcblk_pkg::CODE_OFF_ALT:
                        begin
                            on_next[i]    = 1'b0;
                            blink_next[i] = 1'b0;
                        end
                        mcblk_pkg::CODE_STEADY:
                        begin
                            on_next[i]    = 1'b1;
                            blink_next[i] = 1'b0;
                        end
                        mcblk_pkg::CODE_BLINK, mcblk_pkg::CODE_BLINK_ALT:
                        begin
                            on_next[i]    = 1'b1;
                            blink_next[i] = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            // masks apply even when the code is unknown
            on_next    = on_next & cfg.controllable_mask;
            blink_next = blink_next & cfg.blinkable_mask;
        end
        else
        begin
            for (int i = 0; i < mcblk_pkg::CHANNELS; i++)
            begin
                if (cfg.controllable_mask[i])
                begin
                    if (blink_reg[i])
                    begin
                        if (on_reg[i])
                        begin
                            if (count_reg[i] > cfg.blink_limit)
                            begin
                                count_next[i] = '0;
                                level_next[i] = !level_reg[i];
                            end
                            else
                            begin
                                // wraps at the top of the counter
                                count_next[i] = count_reg[i] + 1'b1;
                            end
                        end
                        else
                        begin
                            level_next[i] = 1'b0;
                        end
                    end
                    else
                    begin
                        level_next[i] = on_reg[i];
                    end
                end
            end
        end
    end

    assign result.levels  = level_next;
    assign result.changed = level_next ^ level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg    <= '0;
            blink_reg <= '0;
            level_reg <= '0;
            for (int i = 0; i < mcblk_pkg::CHANNELS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            on_reg    <= on_next;
            blink_reg <= blink_next;
            level_reg <= level_next;
            for (int i = 0; i < mcblk_pkg::CHANNELS; i++)
            begin
                count_reg[i] <= count_next[i];
            end
        end
    end

`ifndef SYNTHESIS
    a_cmd_keeps_levels: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.op == mcblk_pkg::OP_CMD) |=> level_reg == $past(level_reg))
        else $error("command beat changed levels");

    a_cmd_on_masked: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.op == mcblk_pkg::OP_CMD)
            |=> (on_reg & ~$past(cfg.controllable_mask)) == '0)
        else $error("on bit set outside controllable mask");

    a_cmd_blink_masked: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.op == mcblk_pkg::OP_CMD)
            |=> (blink_reg & ~$past(cfg.blinkable_mask)) == '0)
        else $error("blink bit set outside blinkable mask");

    a_tick_keeps_modes: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.op == mcblk_pkg::OP_TICK) |=> $stable(on_reg) && $stable(blink_reg))
        else $error("tick beat changed channel modes");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(level_reg))
        else $error("levels moved without a beat");
`endif

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: testbench for the sixteen-channel blink output controller
// Directed beats from a table, then random command and tick beats over several
// register settings and handshake pacing; every result is checked in order against
// table values or a cycle-free model of channel modes, levels and blink counters.
// ---------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PLAN_ROWS    = 30;
    localparam int PHASES       = 7;
    localparam int PHASE_BEATS  = 250;
    localparam int DRAIN_CYCLES = 4;

    typedef enum logic [1:0] {ROW_BEAT, ROW_TYPED, ROW_REG} row_kind_e;

    typedef struct packed {
        row_kind_e                      kind;
        mcblk_pkg::cmd_item_t           beat;
        mcblk_pkg::res_item_t           want;
        logic [1:0]                     reg_idx;
        logic [mcblk_pkg::DATA_W-1:0]   reg_val;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    mcblk_pkg::cmd_item_t cmd = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    mcblk_pkg::res_item_t res;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [mcblk_pkg::ADDR_W-1:0] paddr = '0;
    logic [mcblk_pkg::DATA_W-1:0] pwdata = '0;
    logic [mcblk_pkg::DATA_W-1:0] prdata;
    logic pready;

    // Channel model state and its register copy
    logic [mcblk_pkg::CHANNELS-1:0] ch_on = '0;
    logic [mcblk_pkg::CHANNELS-1:0] ch_blink = '0;
    logic [mcblk_pkg::CHANNELS-1:0] ch_level = '0;
    logic [mcblk_pkg::CNT_W-1:0]    ch_count [mcblk_pkg::CHANNELS];
    logic [mcblk_pkg::CHANNELS-1:0] ctl_mask = mcblk_pkg::CTRL_MASK_RST;
    logic [mcblk_pkg::CHANNELS-1:0] blk_mask = mcblk_pkg::BLINK_MASK_RST;
    logic [mcblk_pkg::CNT_W-1:0]    blk_limit = mcblk_pkg::BLINK_LIM_RST;

    mcblk_pkg::res_item_t levels_due [$];
    logic                 typed_due = 1'b0;
    mcblk_pkg::res_item_t typed_want = '0;

    int fault_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;

    row_t plan [PLAN_ROWS];

    multi_channel_blink_output_control_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver pacing; a pending hold-off wins over random stalls
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            res_stall = 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            res_stall = ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic log_fault(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        fault_count++;
    endtask

    task automatic advance_channels(input mcblk_pkg::cmd_item_t b,
                                    output mcblk_pkg::res_item_t r);
        logic [mcblk_pkg::CHANNELS-1:0] prior;
        logic [mcblk_pkg::CHANNELS-1:0] sel;
        logic [mcblk_pkg::CNT_W-1:0]    old;
        prior = ch_level;
        if (b.op == mcblk_pkg::OP_CMD)
        begin
            sel = '0;
            sel[b.channel] = 1'b1;
            if (b.command_code == mcblk_pkg::CODE_OFF ||
                b.command_code == mcblk_pkg::CODE_OFF_ALT)
            begin
                ch_on    &= ~sel;
                ch_blink &= ~sel;
            end
            else if (b.command_code == mcblk_pkg::CODE_STEADY)
            begin
                ch_on    |= sel;
                ch_blink &= ~sel;
            end
            else if (b.command_code == mcblk_pkg::CODE_BLINK ||
                     b.command_code == mcblk_pkg::CODE_BLINK_ALT)
            begin
                ch_on    |= sel;
                ch_blink |= sel;
            end
            // masks apply even when the code is ignored
            ch_on    &= ctl_mask;
            ch_blink &= blk_mask;
        end
        else
        begin
            for (int i = 0; i < mcblk_pkg::CHANNELS; i++)
            begin
                if (!ctl_mask[i])
                    continue;
                if (ch_blink[i])
                begin
                    if (ch_on[i])
                    begin
                        old = ch_count[i];
                        if (old > blk_limit)
                        begin
                            ch_count[i] = '0;
                            ch_level[i] = ~ch_level[i];
                        end
                        else
                        begin
                            ch_count[i] = old + 1'b1;
                        end
                    end
                    else
                    begin
                        ch_level[i] = 1'b0;
                    end
                end
                else
                begin
                    ch_level[i] = ch_on[i];
                end
            end
        end
        r.levels  = ch_level;
        r.changed = ch_level ^ prior;
    endtask

    // Check accepted results, then predict for the accepted command beat
    always @(posedge clk)
    begin
        mcblk_pkg::res_item_t want;
        mcblk_pkg::res_item_t fresh;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (levels_due.size() == 0)
                begin
                    log_fault($sformatf("unexpected result levels=%h changed=%h",
                                        res.levels, res.changed));
                end
                else
                begin
                    want = levels_due.pop_front();
                    if (res.levels !== want.levels)
                        log_fault($sformatf("levels got %h want %h",
                                            res.levels, want.levels));
                    if (res.changed !== want.changed)
                        log_fault($sformatf("changed got %h want %h",
                                            res.changed, want.changed));
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                advance_channels(cmd, fresh);
                levels_due.push_back(typed_due ? typed_want : fresh);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_beat(input mcblk_pkg::cmd_item_t b, input logic typed,
                             input mcblk_pkg::res_item_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid = 1'b0;
            @(negedge clk);
        end
        cmd_valid  = 1'b1;
        cmd        = b;
        typed_due  = typed;
        typed_want = want;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic settle_block();
        cmd_valid = 1'b0;
        while (levels_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx,
                             input logic [mcblk_pkg::DATA_W-1:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            mcblk_pkg::REG_CTRL_MASK:  ctl_mask  = val[mcblk_pkg::CHANNELS-1:0];
            mcblk_pkg::REG_BLINK_MASK: blk_mask  = val[mcblk_pkg::CHANNELS-1:0];
            mcblk_pkg::REG_BLINK_LIM:  blk_limit = val[mcblk_pkg::CNT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic row_t row_beat(input logic op,
                                      input logic [mcblk_pkg::CH_W-1:0] ch,
                                      input logic [mcblk_pkg::CODE_W-1:0] code);
        row_t r;
        r = '0;
        r.kind = ROW_BEAT;
        r.beat = '{op, ch, code};
        return r;
    endfunction

    function automatic row_t row_typed(input logic op,
                                       input logic [mcblk_pkg::CH_W-1:0] ch,
                                       input logic [mcblk_pkg::CODE_W-1:0] code,
                                       input logic [mcblk_pkg::CHANNELS-1:0] lv,
                                       input logic [mcblk_pkg::CHANNELS-1:0] chg);
        row_t r;
        r = row_beat(op, ch, code);
        r.kind = ROW_TYPED;
        r.want = '{lv, chg};
        return r;
    endfunction

    function automatic row_t row_reg(input logic [1:0] idx,
                                     input logic [mcblk_pkg::DATA_W-1:0] val);
        row_t r;
        r = '0;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic mcblk_pkg::cmd_item_t random_beat();
        mcblk_pkg::cmd_item_t b;
        b.op      = $urandom_range(0, 1) ? mcblk_pkg::OP_TICK : mcblk_pkg::OP_CMD;
        b.channel = mcblk_pkg::CH_W'($urandom_range(0, mcblk_pkg::CHANNELS - 1));
        case ($urandom_range(0, 5))
            0: b.command_code = mcblk_pkg::CODE_OFF;
            1: b.command_code = mcblk_pkg::CODE_OFF_ALT;
            2: b.command_code = mcblk_pkg::CODE_STEADY;
            3: b.command_code = mcblk_pkg::CODE_BLINK;
            4: b.command_code = mcblk_pkg::CODE_BLINK_ALT;
            default: b.command_code = mcblk_pkg::CODE_W'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    initial
    begin
        logic [mcblk_pkg::DATA_W-1:0] ctl_v;
        logic [mcblk_pkg::DATA_W-1:0] blk_v;
        logic [mcblk_pkg::DATA_W-1:0] lim_v;

        for (int i = 0; i < mcblk_pkg::CHANNELS; i++)
            ch_count[i] = '0;

        // Default masks: channels 2..13 controllable, 2..7 blinkable, limit 20
        plan[0]  = row_typed(mcblk_pkg::OP_CMD,  4'd0,  mcblk_pkg::CODE_STEADY,
                             16'h0000, 16'h0000);
        plan[1]  = row_typed(mcblk_pkg::OP_TICK, 4'd0,  mcblk_pkg::CODE_OFF,
                             16'h0000, 16'h0000);
        plan[2]  = row_typed(mcblk_pkg::OP_CMD,  4'd2,  mcblk_pkg::CODE_STEADY,
                             16'h0000, 16'h0000);
        plan[3]  = row_typed(mcblk_pkg::OP_TICK, 4'd9,  8'hFF,
                             16'h0004, 16'h0004);
        plan[4]  = row_typed(mcblk_pkg::OP_CMD,  4'd3,  mcblk_pkg::CODE_BLINK,
                             16'h0004, 16'h0000);
        plan[5]  = row_typed(mcblk_pkg::OP_CMD,  4'd15, mcblk_pkg::CODE_BLINK_ALT,
                             16'h0004, 16'h0000);
        plan[6]  = row_typed(mcblk_pkg::OP_CMD,  4'd8,  mcblk_pkg::CODE_BLINK,
                             16'h0004, 16'h0000);
        plan[7]  = row_typed(mcblk_pkg::OP_TICK, 4'd0,  mcblk_pkg::CODE_OFF,
                             16'h0104, 16'h0100);
        plan[8]  = row_typed(mcblk_pkg::OP_CMD,  4'd2,  mcblk_pkg::CODE_OFF_ALT,
                             16'h0104, 16'h0000);
        plan[9]  = row_typed(mcblk_pkg::OP_TICK, 4'd0,  mcblk_pkg::CODE_OFF,
                             16'h0100, 16'h0004);
        plan[10] = row_beat(mcblk_pkg::OP_CMD,  4'd4,  8'h03);
        plan[11] = row_beat(mcblk_pkg::OP_CMD,  4'd5,  8'hFF);
        // Limit below the running count: next tick toggles
        plan[12] = row_reg(mcblk_pkg::REG_BLINK_LIM, 32'd0);
        plan[13] = row_beat(mcblk_pkg::OP_TICK, 4'd0,  mcblk_pkg::CODE_OFF);
        plan[14] = row_beat(mcblk_pkg::OP_TICK, 4'd0,  mcblk_pkg::CODE_OFF);
        plan[15] = row_beat(mcblk_pkg::OP_TICK, 4'd0,  mcblk_pkg::CODE_OFF);
        plan[16] = row_reg(mcblk_pkg::REG_CTRL_MASK,  32'h0000_FFFF);
        plan[17] = row_reg(mcblk_pkg::REG_BLINK_MASK, 32'h0000_FFFF);
        plan[18] = row_beat(mcblk_pkg::OP_CMD,  4'd15, mcblk_pkg::CODE_BLINK_ALT);
        plan[19] = row_beat(mcblk_pkg::OP_CMD,  4'd0,  mcblk_pkg::CODE_OFF);
        plan[20] = row_beat(mcblk_pkg::OP_TICK, 4'd0,  mcblk_pkg::CODE_OFF);
        // Limit at its top: the counter wraps and never toggles
        plan[21] = row_reg(mcblk_pkg::REG_BLINK_LIM, 32'd31);
        plan[22] = row_beat(mcblk_pkg::OP_TICK, 4'd0,  mcblk_pkg::CODE_OFF);
        plan[23] = row_beat(mcblk_pkg::OP_CMD,  4'd3,  mcblk_pkg::CODE_OFF);
        plan[24] = row_beat(mcblk_pkg::OP_CMD,  4'd3,  mcblk_pkg::CODE_BLINK);
        plan[25] = row_beat(mcblk_pkg::OP_TICK, 4'd0,  mcblk_pkg::CODE_OFF);
        plan[26] = row_reg(mcblk_pkg::REG_CTRL_MASK,  32'h0000_0000);
        plan[27] = row_reg(mcblk_pkg::REG_BLINK_MASK, 32'h0000_0000);
        plan[28] = row_beat(mcblk_pkg::OP_TICK, 4'd0,  mcblk_pkg::CODE_OFF);
        plan[29] = row_beat(mcblk_pkg::OP_CMD,  4'd7,  mcblk_pkg::CODE_STEADY);

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[r])
        begin
            if (plan[r].kind == ROW_REG)
            begin
                settle_block();
                write_reg(plan[r].reg_idx, plan[r].reg_val);
            end
            else
            begin
                send_beat(plan[r].beat, plan[r].kind == ROW_TYPED, plan[r].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle_block();
            case (ph)
                0:
                begin
                    ctl_v = mcblk_pkg::CTRL_MASK_RST;
                    blk_v = mcblk_pkg::BLINK_MASK_RST;
                    lim_v = mcblk_pkg::BLINK_LIM_RST;
                end
                1:
                begin
                    ctl_v = 32'h0000_FFFF;
                    blk_v = 32'h0000_FFFF;
                    lim_v = 32'd0;
                end
                2:
                begin
                    ctl_v = $urandom_range(0, 16'hFFFF);
                    blk_v = $urandom_range(0, 16'hFFFF);
                    lim_v = 32'd31;
                end
                3:
                begin
                    ctl_v = 32'h0000_0000;
                    blk_v = 32'h0000_0000;
                    lim_v = 32'd30;
                end
                default:
                begin
                    ctl_v = $urandom_range(0, 16'hFFFF);
                    blk_v = $urandom_range(0, 16'hFFFF);
                    lim_v = $urandom_range(0, 31);
                end
            endcase
            write_reg(mcblk_pkg::REG_CTRL_MASK, ctl_v);
            write_reg(mcblk_pkg::REG_BLINK_MASK, blk_v);
            write_reg(mcblk_pkg::REG_BLINK_LIM, lim_v);

            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 46;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 46;
                end
                default:
                begin
                    send_idle_pct = 11;
                    stall_pct     = 11;
                end
            endcase

            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                // Hold the result side off long enough to back up the input
                if (ph == 0 && n == 100)
                    hold_left = 60;
                send_beat(random_beat(), 1'b0, '0);
            end
        end

        cmd_valid = 1'b0;
        while (levels_due.size() != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
        if (fault_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
hdl/mcblk_pkg.sv
hdl/mcblk_cfg.sv
hdl/mcblk_core.sv
hdl/multi_channel_blink_output_control_core.sv
sim/tb.sv
